>>> rtl/normal_pack_11_11_10_codec_top_assert.svh
// Assertion macros for the 11/11/10 normal codec checker.
// No dependencies; taken in by the checker file.
`ifndef NORMAL_PACK_11_11_10_CODEC_TOP_ASSERT_SVH
`define NORMAL_PACK_11_11_10_CODEC_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define NPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normal codec check failed");

// Next-cycle implication, disabled in reset.
`define NPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normal codec check failed");

`endif

>>> rtl/nrm_pkg.sv
// Shared constants for the 11/11/10 normal codec.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrm_pkg;
  localparam int FLT_W   = 32;
  localparam int FLD_X_W = 11;
  localparam int FLD_Y_W = 11;
  localparam int FLD_Z_W = 10;
  // pipeline depth of every lane, and of the whole block with the merge stage
  localparam int LANE_LAT = 4;
  localparam int OUT_LAT  = LANE_LAT + 1;
  localparam logic [FLT_W-1:0] FLT_POS_ONE = 32'h3F80_0000;
  localparam logic [FLT_W-1:0] FLT_NEG_ONE = 32'hBF80_0000;
endpackage
`default_nettype wire

>>> rtl/normal_pack_11_11_10_codec_top.sv
// Top level of the 11/11/10 normal codec: three pack lanes, three unpack lanes, merge.
// Depends on nrm_pkg, nrm_pack_lane, nrm_unpack_lane.
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+---------------------------
//  input    | start, busy, in_float_x/y/z, in_packed_in | edge with start & !busy
//  result   | out_valid, out_packed_out, out_unpacked_*  | edge ending out_valid cycle
//
// One item may be transferred every cycle while busy is low; each result appears once its
// input has passed the four lane stages and the merge register, for one cycle only.
// The depth is set by the pack lane: decode, multiply, first rounding, half-add/round.
// Reset (rst_n low, synchronous) empties the valid pipeline and holds busy high;
// busy drops at the first clock edge with rst_n high and stays low.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
`default_nettype none
module normal_pack_11_11_10_codec_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [nrm_pkg::FLT_W-1:0] in_float_x,
  input  wire logic [nrm_pkg::FLT_W-1:0] in_float_y,
  input  wire logic [nrm_pkg::FLT_W-1:0] in_float_z,
  input  wire logic [nrm_pkg::FLT_W-1:0] in_packed_in,
  output logic                           out_valid,
  output logic [nrm_pkg::FLT_W-1:0]      out_packed_out,
  output logic [nrm_pkg::FLT_W-1:0]      out_unpacked_x,
  output logic [nrm_pkg::FLT_W-1:0]      out_unpacked_y,
  output logic [nrm_pkg::FLT_W-1:0]      out_unpacked_z
);
  localparam int XW = nrm_pkg::FLD_X_W;
  localparam int YW = nrm_pkg::FLD_Y_W;
  localparam int ZW = nrm_pkg::FLD_Z_W;

  logic                         busy_r, busy_nxt;
  logic [nrm_pkg::OUT_LAT-1:0]  vld_r, vld_nxt;
  logic                         accept;
  logic [XW-1:0]                fx;
  logic [YW-1:0]                fy;
  logic [ZW-1:0]                fz;
  logic [nrm_pkg::FLT_W-1:0]    ux, uy, uz;
  logic [nrm_pkg::FLT_W-1:0]    packed_r, ux_r, uy_r, uz_r;

  assign accept = start && !busy_r;

  // pack lanes, one per component
  nrm_pack_lane #(.WIDTH(XW)) u_pack_x (.clk(clk), .f_in(in_float_x), .field_out(fx));
  nrm_pack_lane #(.WIDTH(YW)) u_pack_y (.clk(clk), .f_in(in_float_y), .field_out(fy));
  nrm_pack_lane #(.WIDTH(ZW)) u_pack_z (.clk(clk), .f_in(in_float_z), .field_out(fz));

  // unpack lanes, fed from the fields of the packed word
  nrm_unpack_lane #(.WIDTH(XW)) u_unpack_x (
    .clk(clk), .field_in(in_packed_in[XW-1:0]), .value_out(ux));
  nrm_unpack_lane #(.WIDTH(YW)) u_unpack_y (
    .clk(clk), .field_in(in_packed_in[XW+YW-1:XW]), .value_out(uy));
  nrm_unpack_lane #(.WIDTH(ZW)) u_unpack_z (
    .clk(clk), .field_in(in_packed_in[XW+YW+ZW-1:XW+YW]), .value_out(uz));

  always_comb begin
    busy_nxt = 1'b0;
    vld_nxt  = {vld_r[nrm_pkg::OUT_LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // merge stage: fields into one word, unpacked values alongside
  always_ff @(posedge clk) begin
    packed_r <= {fz, fy, fx};
    ux_r     <= ux;
    uy_r     <= uy;
    uz_r     <= uz;
  end

  assign busy           = busy_r;
  assign out_valid      = vld_r[nrm_pkg::OUT_LAT-1];
  assign out_packed_out = packed_r;
  assign out_unpacked_x = ux_r;
  assign out_unpacked_y = uy_r;
  assign out_unpacked_z = uz_r;
endmodule
`default_nettype wire

>>> rtl/nrm_pack_lane.sv
// Pack lane: one float to a WIDTH-bit signed-normal field, four stages.
// Depends on nrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrm_pack_lane #(
  parameter int WIDTH = nrm_pkg::FLD_Z_W
) (
  input  wire logic                      clk,
  input  wire logic [nrm_pkg::FLT_W-1:0] f_in,
  output logic      [WIDTH-1:0]          field_out
);
  localparam int P    = WIDTH - 1;
  localparam int OP_W = 53;
  localparam int X_W  = OP_W + P;
  localparam int PF_W = P + 36;
  localparam logic [P-1:0] MAG = {P{1'b1}};

  typedef enum logic [1:0] {PK_ZERO, PK_MAG, PK_CALC} pk_cls_t;
  typedef struct packed {
    pk_cls_t    cls;
    logic       neg;
    logic [3:0] sh;
  } stg_t;

  function automatic logic [X_W:0] rne_drop(input logic [X_W-1:0] v, input int unsigned d);
    logic [X_W:0] unit;
    logic [X_W:0] rem;
    logic [X_W:0] half;
    logic [X_W:0] keep;
    logic         up;
    unit = (X_W+1)'(1) << d;
    rem  = {1'b0, v} & (unit - 1'b1);
    half = unit >> 1;
    keep = {1'b0, v} & ~(unit - 1'b1);
    up   = (rem > half) || ((rem == half) && ((keep & unit) != '0));
    rne_drop = keep + (up ? unit : '0);
  endfunction

  // stage 1: decode
  logic           sgn, is_nan, is_zero;
  logic [7:0]     be;
  logic [22:0]    fr;
  logic [52:0]    a_v;
  logic [53:0]    t_full;
  stg_t           ctl_nxt, ctl1_r, ctl2_r, ctl3_r;
  logic [OP_W-1:0] op_nxt, op1_r;

  always_comb begin
    sgn     = f_in[31];
    be      = f_in[30:23];
    fr      = f_in[22:0];
    is_nan  = (be == 8'hFF) && (fr != '0);
    is_zero = (be == 8'h00) && (fr == '0);
    a_v     = 53'({1'b1, fr}) << 5'(be - 8'd97);
    t_full  = (54'(1) << 53) - {1'b0, a_v};
    ctl_nxt.neg = sgn && !is_zero && !is_nan;
    ctl_nxt.sh  = 4'(be - 8'd116);
    ctl_nxt.cls = PK_CALC;
    op_nxt      = OP_W'({1'b1, fr});
    if (is_nan || (!ctl_nxt.neg && be < 8'd116)) begin
      ctl_nxt.cls = PK_ZERO;
    end else if (ctl_nxt.neg) begin
      if (be >= 8'd127) begin
        op_nxt = '0;
      end else if (be < 8'd97) begin
        ctl_nxt.cls = PK_MAG;
      end else begin
        op_nxt = t_full[52:0];
      end
    end else if (be >= 8'd127) begin
      op_nxt     = OP_W'(24'h80_0000);
      ctl_nxt.sh = 4'd11;
    end
  end

  // stage 2: scale by the magnitude
  logic [X_W-1:0] x2_r;
  // stage 3: first rounding
  logic           big;
  logic [X_W:0]   xr_nxt, xr3_r;

  always_comb begin
    big    = ctl2_r.neg ? x2_r[52+P] : x2_r[23+P];
    xr_nxt = big ? rne_drop(x2_r, P) : rne_drop(x2_r, P - 1);
  end

  // stage 4: add one half, round, truncate
  logic [PF_W-1:0] p_fx, s_fx;
  logic [P-1:0]    int_p;
  logic [33:0]     frac, lowmask;
  logic [4:0]      kk;
  logic            up_p;
  logic [P:0]      qp, qn;
  logic [X_W-1:0]  sn;
  logic [X_W:0]    srn;
  logic [WIDTH-1:0] field_nxt;

  always_comb begin
    p_fx  = PF_W'(xr3_r[P+24:0]) << ctl3_r.sh;
    s_fx  = p_fx + (PF_W'(1) << 33);
    int_p = s_fx[P+33:34];
    frac  = s_fx[33:0];
    kk    = 5'd9;
    for (int i = 0; i < P; i++) begin
      if (int_p[i]) kk = 5'(i + 10);
    end
    lowmask = (34'(1) << kk) - 34'(1);
    up_p    = &(frac | lowmask);
    qp      = {1'b0, int_p} + (P+1)'(up_p);
    if (qp > {1'b0, MAG}) qp = {1'b0, MAG};
    sn  = xr3_r[X_W-1:0] + (X_W'(1) << 52);
    srn = rne_drop(sn, P);
    qn  = srn[X_W:53];
    if (qn > {1'b0, MAG}) qn = {1'b0, MAG};
    case (ctl3_r.cls)
      PK_ZERO: field_nxt = '0;
      PK_MAG:  field_nxt = {1'b1, MAG};
      PK_CALC: field_nxt = ctl3_r.neg ? {1'b1, qn[P-1:0]} : {1'b0, qp[P-1:0]};
      default: field_nxt = '0;
    endcase
  end

  // times MAG = times 2^P minus once
  always_ff @(posedge clk) begin
    ctl1_r    <= ctl_nxt;
    op1_r     <= op_nxt;
    ctl2_r    <= ctl1_r;
    x2_r      <= (X_W'(op1_r) << P) - X_W'(op1_r);
    ctl3_r    <= ctl2_r;
    xr3_r     <= xr_nxt;
    field_out <= field_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/nrm_unpack_lane.sv
// Unpack lane: WIDTH-bit signed-normal field to an IEEE single.
// Depends on nrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrm_unpack_lane #(
  parameter int WIDTH = nrm_pkg::FLD_Z_W
) (
  input  wire logic                      clk,
  input  wire logic [WIDTH-1:0]          field_in,
  output logic      [nrm_pkg::FLT_W-1:0] value_out
);
  localparam int P   = WIDTH - 1;
  localparam int REP = (25 + P) / P + 2;
  localparam int RW  = REP * P;
  localparam logic [P-1:0] MAG = {P{1'b1}};

  logic                      sb;
  logic [P-1:0]              m, n;
  logic [4:0]                j;
  logic [RW-1:0]             rep, shifted;
  logic [24:0]               top;
  logic [23:0]               mant;
  logic [7:0]                expo;
  logic [nrm_pkg::FLT_W-1:0] val_nxt;
  logic [nrm_pkg::FLT_W-1:0] dly_r [nrm_pkg::LANE_LAT];

  // n/M in binary is the P-bit pattern of n repeated; never an exact tie
  always_comb begin
    sb = field_in[P];
    m  = field_in[P-1:0];
    n  = sb ? (MAG - m) : m;
    j  = '0;
    for (int i = 0; i < P; i++) begin
      if (n[i]) j = 5'(i);
    end
    rep     = {REP{n}};
    shifted = rep << (5'(P - 1) - j);
    top     = shifted[RW-1 -: 25];
    mant    = top[24:1] + 24'(top[0]);
    expo    = 8'(127 - P) + 8'(j);
    if (n == '0) begin
      val_nxt = '0;
    end else if (n == MAG) begin
      val_nxt = sb ? nrm_pkg::FLT_NEG_ONE : nrm_pkg::FLT_POS_ONE;
    end else begin
      val_nxt = {sb, expo, mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= val_nxt;
    for (int i = 1; i < nrm_pkg::LANE_LAT; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign value_out = dly_r[nrm_pkg::LANE_LAT-1];
endmodule
`default_nettype wire

>>> rtl/nrm_checker.sv
// Port-level checker for the normal codec, bound to the top level.
// Depends on normal_pack_11_11_10_codec_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "normal_pack_11_11_10_codec_top_assert.svh"
module nrm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_float_x,
  input wire logic [31:0] in_float_y,
  input wire logic [31:0] in_float_z,
  input wire logic [31:0] in_packed_in,
  input wire logic        out_valid,
  input wire logic [31:0] out_packed_out,
  input wire logic [31:0] out_unpacked_x,
  input wire logic [31:0] out_unpacked_y,
  input wire logic [31:0] out_unpacked_z
);
  // every transfer yields a result strobe
  `NPC_ASSERT_NXT(a_result_follows, clk, rst_n, start && !busy, ##4 out_valid)
  // no result without a transfer
  `NPC_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, 5))
  // NaN in x packs as zero
  `NPC_ASSERT_IMP(a_nan_zero, clk, rst_n,
    start && !busy && in_float_x[30:23] == 8'hFF && in_float_x[22:0] != 23'h0,
    ##5 out_packed_out[10:0] == 11'h0)
  // sign bit with full magnitude reads back as +0
  `NPC_ASSERT_IMP(a_full_mag_zero, clk, rst_n,
    start && !busy && in_packed_in[31:22] == 10'h3FF,
    ##5 out_unpacked_z == 32'h0)
endmodule

bind normal_pack_11_11_10_codec_top nrm_checker u_nrm_checker (.*);
`default_nettype wire

>>> bench/normal_pack_11_11_10_codec_top_test.sv
// Self-checking bench for the 11/11/10 packed normal codec (pack and unpack per item).
// Bit-exact float predictor built on real arithmetic; depends on nrm_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none
module normal_pack_11_11_10_codec_top_test;

  typedef struct packed {
    logic [nrm_pkg::FLT_W-1:0] packed_out;
    logic [nrm_pkg::FLT_W-1:0] unp_x;
    logic [nrm_pkg::FLT_W-1:0] unp_y;
    logic [nrm_pkg::FLT_W-1:0] unp_z;
  } codec_res_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [nrm_pkg::FLT_W-1:0] in_float_x, in_float_y, in_float_z, in_packed_in;
  logic                      out_valid;
  logic [nrm_pkg::FLT_W-1:0] out_packed_out, out_unpacked_x, out_unpacked_y, out_unpacked_z;

  codec_res_t pending_res[$];
  int         n_err;

  normal_pack_11_11_10_codec_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_float_x     (in_float_x),
    .in_float_y     (in_float_y),
    .in_float_z     (in_float_z),
    .in_packed_in   (in_packed_in),
    .out_valid      (out_valid),
    .out_packed_out (out_packed_out),
    .out_unpacked_x (out_unpacked_x),
    .out_unpacked_y (out_unpacked_y),
    .out_unpacked_z (out_unpacked_z)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("normal_pack_11_11_10_codec_top_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Float helpers: convert between single bit patterns and real (double).
  // ---------------------------------------------------------------------------

  // Round a real to single precision (nearest-even), normal range or zero only.
  function automatic logic [31:0] real_to_f32(real x);
    logic [63:0] db;
    logic [62:0] body;
    logic [33:0] kept;
    logic [28:0] dropped;
    logic [10:0] dexp;
    db = $realtobits(x);
    if (x == 0.0) return {db[63], 31'd0};
    body    = db[62:0];
    kept    = body[62:29];
    dropped = body[28:0];
    if (dropped > 29'h1000_0000 || (dropped == 29'h1000_0000 && kept[0]))
      kept = kept + 34'd1;
    dexp = kept[33:23] - 11'd896;
    return {db[63], dexp[7:0], kept[22:0]};
  endfunction

  function automatic real f32_to_real(logic [31:0] f);
    real r;
    if (f[30:23] == 8'd0) begin
      r = real'(f[22:0]) * (2.0 ** (-149));
      return f[31] ? -r : r;
    end
    return $bitstoreal({f[31], {3'd0, f[30:23]} + 11'd896, f[22:0], 29'd0});
  endfunction

  function automatic real round_single(real x);
    // anything this small cannot move the truncated field
    if (x < 2.0 ** (-100)) return x;
    return f32_to_real(real_to_f32(x));
  endfunction

  // Pack one component into a field of fw bits.
  function automatic int unsigned pack_field(logic [31:0] f, int fw);
    int unsigned sbit, mag, q;
    real x, p, s;
    sbit = 1 << (fw - 1);
    mag  = sbit - 1;
    if (f[30:23] == 8'hFF && f[22:0] != 0) return 0;  // NaN packs as zero
    if (f[30:23] == 8'hFF) x = f[31] ? -1.0 : 1.0;
    else x = f32_to_real(f);
    if (x > 1.0) x = 1.0;
    if (x < -1.0) x = -1.0;
    if (x >= 0.0) begin
      // single precision: product rounded, then sum rounded
      p = round_single(x * real'(mag));
      s = round_single(p + 0.5);
      q = $rtoi(s);
      return (q > mag) ? mag : q;
    end
    // double precision path for negatives
    p = (1.0 + x) * real'(mag);
    s = p + 0.5;
    q = $rtoi(s);
    if (q > mag) q = mag;
    return q | sbit;
  endfunction

  function automatic logic [31:0] unpack_field(int unsigned fld, int fw);
    int unsigned sbit, mag;
    real q;
    sbit = 1 << (fw - 1);
    mag  = sbit - 1;
    q = real'(fld & mag) / real'(mag);
    if (fld & sbit) q = q - 1.0;
    return real_to_f32(q);
  endfunction

  function automatic codec_res_t predict_codec(logic [31:0] fx, logic [31:0] fy,
                                               logic [31:0] fz, logic [31:0] word);
    codec_res_t r;
    int unsigned px, py, pz;
    px = pack_field(fx, nrm_pkg::FLD_X_W);
    py = pack_field(fy, nrm_pkg::FLD_Y_W);
    pz = pack_field(fz, nrm_pkg::FLD_Z_W);
    r.packed_out = (px & 32'h7FF) | ((py & 32'h7FF) << 11) | ((pz & 32'h3FF) << 22);
    r.unp_x = unpack_field(32'(word[10:0]), nrm_pkg::FLD_X_W);
    r.unp_y = unpack_field(32'(word[21:11]), nrm_pkg::FLD_Y_W);
    r.unp_z = unpack_field(32'(word[31:22]), nrm_pkg::FLD_Z_W);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened, or after the gap that follows it.
  task automatic send_item(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                           logic [31:0] word, int gap);
    start        <= 1'b1;
    in_float_x   <= fx;
    in_float_y   <= fy;
    in_float_z   <= fz;
    in_packed_in <= word;
    do @(posedge clk); while (busy);
    pending_res.push_back(predict_codec(fx, fy, fz, word));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A float biased towards the interesting parts of the pack range.
  function automatic logic [31:0] pick_float();
    int sel, k, fw;
    real v;
    sel = $urandom_range(99);
    fw  = $urandom_range(1) ? 11 : 10;
    if (sel < 20) return $urandom();
    if (sel < 50) begin
      v = real'($urandom_range(2_000_000)) / 1_000_000.0 - 1.0;
      return real_to_f32(v);
    end
    if (sel < 85) begin
      // right on or next to a rounding boundary of the field
      k = $urandom_range((1 << (fw - 1)) - 1);
      v = (real'(k) + 0.5) / real'((1 << (fw - 1)) - 1);
      if ($urandom_range(1)) v = -v;
      if (v > 1.0) v = 1.0;
      if (v < -1.0) v = -1.0;
      return real_to_f32(v) + 32'($signed($urandom_range(4)) - 2);
    end
    if (sel < 92) return {$urandom_range(1) ? 1'b1 : 1'b0, 8'd0, 23'($urandom())};
    case ($urandom_range(5))
      0: return nrm_pkg::FLT_POS_ONE;
      1: return nrm_pkg::FLT_NEG_ONE;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000 | $urandom_range(32'h3F_FFFF);
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic test_directed();
    // extremes, infinities, NaNs, zeros, out-of-range, subnormals
    send_item(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_item(nrm_pkg::FLT_POS_ONE, nrm_pkg::FLT_NEG_ONE, nrm_pkg::FLT_POS_ONE,
              32'hFFFF_FFFF, 0);
    send_item(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h8020_0400, 0);
    send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFF80_0001, 32'h7FDF_FBFF, 1);
    send_item(32'h4000_0000, 32'hC000_0000, 32'h7F7F_FFFF, 32'h3FEF_F7FF, 0);
    send_item(32'h0000_0001, 32'h8000_0001, 32'h807F_FFFF, 32'h0000_0001, 2);
    send_item(32'h3F00_0000, 32'hBF00_0000, 32'h3F7F_FFFF, 32'h0040_0800, 0);
    send_item(32'hBF7F_FFFF, 32'h3380_0000, 32'hB380_0000, 32'h5555_5555, 0);
    send_item(real_to_f32(0.5 / 1023.0), real_to_f32(-0.5 / 1023.0),
              real_to_f32(0.5 / 511.0), 32'hAAAA_AAAA, 0);
    send_item(real_to_f32(1022.5 / 1023.0), real_to_f32(-1022.5 / 1023.0),
              real_to_f32(-510.5 / 511.0), 32'h8000_0000, 3);
    send_item(32'h0080_0000, 32'h8080_0000, 32'hFF7F_FFFF, 32'h003F_FFFF, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_item(pick_float(), pick_float(), pick_float(), $urandom(), pick_gap());
  endtask

  // ---------------------------------------------------------------------------
  // Result check: every strobed result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    codec_res_t want;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing expected");
        n_err++;
      end else begin
        want = pending_res.pop_front();
        if (out_packed_out !== want.packed_out) begin
          $error("packed_out: expected %h, got %h", want.packed_out, out_packed_out);
          n_err++;
        end
        if (out_unpacked_x !== want.unp_x) begin
          $error("unpacked_x: expected %h, got %h", want.unp_x, out_unpacked_x);
          n_err++;
        end
        if (out_unpacked_y !== want.unp_y) begin
          $error("unpacked_y: expected %h, got %h", want.unp_y, out_unpacked_y);
          n_err++;
        end
        if (out_unpacked_z !== want.unp_z) begin
          $error("unpacked_z: expected %h, got %h", want.unp_z, out_unpacked_z);
          n_err++;
        end
      end
    end
  end

  initial begin
    int waited;
    n_err        = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_float_x   = '0;
    in_float_y   = '0;
    in_float_z   = '0;
    in_packed_in = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(1250);
    start <= 1'b0;

    // drain, then wait on for any stray strobe
    waited = 0;
    while (pending_res.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_res.size() != 0) begin
      $error("%0d results never arrived", pending_res.size());
      n_err++;
    end
    repeat (nrm_pkg::OUT_LAT + 5) @(posedge clk);
    if (n_err == 0) begin
      $display("normal_pack_11_11_10_codec_top_test: clean");
    end else begin
      $display("normal_pack_11_11_10_codec_top_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
